// File: sv/bass_pkg.sv
// ----------------------------------------------------------------------------
// bass_pkg
// shared sizes, types and cell control for the byte sorter with statistics
// ----------------------------------------------------------------------------
package bass_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int BYTE_W       = 8;
  localparam int BYTE_MAX     = (1 << BYTE_W) - 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = $clog2(MAX_ELEMENTS * BYTE_MAX + 1);
  localparam int DIV_CW       = $clog2(SUM_W + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // one command per cycle to every cell of the chain
  typedef struct packed {
    logic load;    // ordered insert of the incoming sample
    logic rotate;  // circular shift towards the head over the filled cells
    logic drain;   // shift towards the head, tail fills with empty cells
  } cell_ctl_t;

endpackage

// File: sv/bass_if.sv
// ----------------------------------------------------------------------------
// bass_in_if / bass_out_if
// valid/ready channels for sample beats and sorted result beats
// ----------------------------------------------------------------------------
interface bass_in_if;
  import bass_pkg::*;

  logic  valid;
  logic  ready;
  byte_t sample;
  logic  is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface bass_out_if;
  import bass_pkg::*;

  logic  valid;
  logic  ready;
  byte_t sorted_byte;
  byte_t largest;
  byte_t smallest;
  byte_t average;
  byte_t middle;
  logic  overflowed;
  logic  final_res;

  modport source (output valid, output sorted_byte, output largest, output smallest,
                  output average, output middle, output overflowed, output final_res,
                  input ready);
  modport sink   (input valid, input sorted_byte, input largest, input smallest,
                  input average, input middle, input overflowed, input final_res,
                  output ready);
endinterface

// File: sv/bass_cell.sv
// ----------------------------------------------------------------------------
// bass_cell
// one slot of the sorting chain, holds one byte in descending order
// ----------------------------------------------------------------------------
module bass_cell (
  input  logic               clk,
  input  logic               rst,
  input  bass_pkg::cell_ctl_t ctl,
  input  bass_pkg::byte_t    sample,
  input  bass_pkg::byte_t    head,
  input  logic               wrap,
  input  bass_pkg::byte_t    left_value,
  input  logic               left_valid,
  input  logic               left_greater,
  input  bass_pkg::byte_t    right_value,
  input  logic               right_valid,
  output bass_pkg::byte_t    value,
  output logic               valid,
  output logic               greater
);
  import bass_pkg::*;

  // an empty slot counts as smaller than anything
  assign greater = !valid || (sample > value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      if (left_greater) begin
        value <= left_value;
        valid <= left_valid;
      end else if (greater) begin
        value <= sample;
        valid <= 1'b1;
      end
    end else if (ctl.rotate) begin
      value <= wrap ? head : right_value;
    end else if (ctl.drain) begin
      value <= right_value;
      valid <= right_valid;
    end
  end

endmodule

// File: sv/bass_div.sv
// ----------------------------------------------------------------------------
// bass_div
// restoring divider, one quotient bit per cycle, for the set mean
// ----------------------------------------------------------------------------
module bass_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bass_pkg::sum_t  dividend,
  input  bass_pkg::count_t divisor,
  output logic            busy,
  output bass_pkg::sum_t  quotient
);
  import bass_pkg::*;

  logic [DIV_CW-1:0] iter;
  count_t            rem;
  count_t            dsr;
  sum_t              quo;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign diff     = rem_sh - {1'b0, dsr};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= DIV_CW'(SUM_W);
      rem  <= '0;
      quo  <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits the count width
      rem  <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo  <= {quo[SUM_W-2:0], fits};
      iter <= iter - DIV_CW'(1);
      if (iter == DIV_CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: sv/byte_array_sort_and_statistics.sv
// ----------------------------------------------------------------------------
// byte_array_sort_and_statistics
// descending byte sorter with max, min, mean and median of each set
// ----------------------------------------------------------------------------
// usage
//   samples: one unsigned byte per beat; is_last closes the set and is itself
//   part of it. up to MAX_ELEMENTS bytes are kept, later ones are dropped and
//   the set is marked overflowed.
//   results: one beat per stored byte, largest first; every beat carries the
//   set's largest, smallest, truncated mean and median, final_res on the last.
// timing
//   load: up to one byte per cycle, bytes go straight into an ordered chain of cells
//   statistics: the chain rotates once over its n filled cells to pick off max,
//   min and median at the head, while the mean divider runs; the phase ends
//   once the rotation is complete and the divider is no longer busy
//   drain: one result beat per cycle while results.ready is high, the chain shifts towards the head
// reset and stalls
//   reset empties the chain and clears count, sum and overflow; samples.ready
//   is held low while rst is high and rises as soon as it is released.
//   samples.ready is low from the last beat of a set until its final result
//   is taken. a stalled result beat holds, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module byte_array_sort_and_statistics (
  input  logic        clk,
  input  logic        rst,
  bass_in_if.sink     samples,
  bass_out_if.source  results
);
  import bass_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_STAT,
    S_OUT
  } state_t;

  state_t    state;
  count_t    cnt;          // filled cells
  count_t    step;         // rotation steps done
  sum_t      sum;
  logic      ovf;
  byte_t     largest_q;
  byte_t     smallest_q;
  byte_t     avg_q;
  byte_t     mid_q;
  byte_t     med_lo;
  byte_t     med_hi;

  // chain of cells; each element is read by its neighbours, the head also by every cell and the output
  byte_t     cell_val [MAX_ELEMENTS];
  logic      cell_vld [MAX_ELEMENTS];
  logic      cell_gt  [MAX_ELEMENTS];

  cell_ctl_t ctl;
  logic      in_beat;
  logic      out_beat;
  logic      full;
  logic      div_busy;
  sum_t      div_quo;
  sum_t      sum_next;
  count_t    cnt_next;
  count_t    half;
  count_t    last_idx;
  logic [BYTE_W:0] mid_sum;

  assign in_beat  = samples.valid && samples.ready;
  assign out_beat = results.valid && results.ready;
  assign full     = (cnt == count_t'(MAX_ELEMENTS));
  assign half     = cnt >> 1;
  assign last_idx = cnt - count_t'(1);
  assign mid_sum  = {1'b0, med_lo} + {1'b0, med_hi};

  // no beat is taken while reset is held
  assign samples.ready = (state == S_LOAD) && !rst;

  always_comb begin
    ctl.load   = in_beat && !full;
    ctl.rotate = (state == S_STAT) && (step != cnt);
    ctl.drain  = out_beat;
    sum_next   = full ? sum : sum + sum_t'(samples.sample);
    cnt_next   = full ? cnt : cnt + count_t'(1);
  end

  // the chain
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    byte_t  l_val;
    logic   l_vld;
    logic   l_gt;
    byte_t  r_val;
    logic   r_vld;
    logic   wrap;

    if (i == 0) begin : g_head
      assign l_val = '0;
      assign l_vld = 1'b0;
      assign l_gt  = 1'b0;
    end else begin : g_body
      assign l_val = cell_val[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_gt  = cell_gt[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end

    // the last filled cell takes the head value back during rotation
    assign wrap = (last_idx == count_t'(i));

    bass_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .sample       (samples.sample),
      .head         (cell_val[0]),
      .wrap         (wrap),
      .left_value   (l_val),
      .left_valid   (l_vld),
      .left_greater (l_gt),
      .right_value  (r_val),
      .right_valid  (r_vld),
      .value        (cell_val[i]),
      .valid        (cell_vld[i]),
      .greater      (cell_gt[i])
    );
  end

  // mean of the set, started on the closing beat
  bass_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_beat && samples.is_last),
    .dividend (sum_next),
    .divisor  (cnt_next),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      step  <= '0;
      sum   <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              cnt <= cnt_next;
              sum <= sum_next;
            end
            if (samples.is_last) begin
              state <= S_STAT;
              step  <= '0;
            end
          end
        end
        S_STAT: begin
          if (ctl.rotate) begin
            // head shows element number step of the sorted set
            step <= step + count_t'(1);
            if (step == '0) begin
              largest_q <= cell_val[0];
            end
            if (step == last_idx) begin
              smallest_q <= cell_val[0];
            end
            if (step + count_t'(1) == half) begin
              med_lo <= cell_val[0];
            end
            if (step == half) begin
              med_hi <= cell_val[0];
            end
          end else if (!div_busy) begin
            state <= S_OUT;
            avg_q <= div_quo[BYTE_W-1:0];
            mid_q <= cnt[0] ? med_hi : mid_sum[BYTE_W:1];
          end
        end
        S_OUT: begin
          if (out_beat) begin
            cnt <= cnt - count_t'(1);
            if (cnt == count_t'(1)) begin
              state <= S_LOAD;
              sum   <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign results.valid       = (state == S_OUT);
  assign results.sorted_byte = cell_val[0];
  assign results.largest     = largest_q;
  assign results.smallest    = smallest_q;
  assign results.average     = avg_q;
  assign results.middle      = mid_q;
  assign results.overflowed  = ovf;
  assign results.final_res   = (cnt == count_t'(1));

endmodule

// File: sv/bass_checker.sv
// ----------------------------------------------------------------------------
// bass_checker
// port level checks on the byte sorter, bound to the top level
// ----------------------------------------------------------------------------
module bass_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_last,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_final,
  input bass_pkg::byte_t sorted_byte,
  input bass_pkg::byte_t largest,
  input bass_pkg::byte_t smallest
);
  import bass_pkg::*;

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result beat is offered");

  // a closing beat stops further loading
  a_close_set: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still ready after the closing beat");

  // the final result beat reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_final |=> in_ready && !out_valid)
    else $error("input not reopened after the final result beat");

  // every result lies between the set's smallest and largest
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (largest >= sorted_byte) && (sorted_byte >= smallest))
    else $error("sorted byte outside the set bounds");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_byte))
    else $error("stalled result beat changed");

endmodule

bind byte_array_sort_and_statistics bass_checker u_bass_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .in_last     (samples.is_last),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_final   (results.final_res),
  .sorted_byte (results.sorted_byte),
  .largest     (results.largest),
  .smallest    (results.smallest)
);

// File: bench/tb_byte_array_sort_and_statistics.sv
// ----------------------------------------------------------------------------
// tb_byte_array_sort_and_statistics
// checks sorted output and per-set statistics of the byte sorter under stalls
// ----------------------------------------------------------------------------
// sets of sample bytes go in through the sample channel. A behavioural
// predictor keeps its own copy of the set. When a set closes, the predictor
// sorts it, works out max, min, truncated mean and median, and queues one
// expected result beat per kept byte. Every result beat taken from the block
// is compared field by field against the oldest expected beat. Both channels
// idle at random, in stretches, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_byte_array_sort_and_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  import bass_pkg::*;

  typedef struct {
    byte_t sample;
    logic  is_last;
  } sample_beat_t;

  typedef struct {
    byte_t sorted_byte;
    byte_t largest;
    byte_t smallest;
    byte_t average;
    byte_t middle;
    logic  overflowed;
    logic  final_res;
  } result_beat_t;

  localparam int RANDOM_ITEMS = 310;
  localparam int MAX_GAP      = 10;
  localparam int SETTLE_WAIT  = 4 * MAX_ELEMENTS + 2 * SUM_W;  // cycles after the last beat
  localparam int PRINT_CAP    = 40;

  logic clk;
  logic rst;

  bass_in_if  samples_if ();
  bass_out_if results_if ();

  byte_array_sort_and_statistics i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  // beats still to be offered, filled up front by the stimulus block
  sample_beat_t pending_samples[$];
  // result beats the predictor has worked out but the block has not yet sent
  result_beat_t awaited_results[$];

  // predictor's own copy of the set being collected
  byte_t held_bytes[$];
  int    held_sum;
  bit    held_over;

  int  mismatches;
  bit  sample_taken;
  bit  result_taken;
  int  gap_left;
  int  stall_left;
  int  in_run, out_run;
  bit  in_quiet, out_quiet;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2ns;
    clk = 1'b1;
    #2ns;
  end

  // generous guard against a hung handshake
  initial begin
    #400us;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  // four-state compare, so unknown bits on the bus count as a mismatch
  task automatic check_field(input string tag, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d want %0d", tag, got, want));
    end
  endtask

  // idle length for one beat; runs of random idling alternate with quiet runs
  function automatic int pick_wait(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 30);
      quiet    = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // take one accepted sample; on the closing byte sort the set and queue results
  task automatic sort_and_summarise(input byte_t sample, input logic is_last);
    byte_t        ordered[$];
    result_beat_t beat;
    int           n;
    int           half;
    int           median;
    // a full store drops the byte but a closing byte still ends the set
    if (held_bytes.size() < MAX_ELEMENTS) begin
      held_bytes.push_back(sample);
      held_sum += sample;
    end else begin
      held_over = 1'b1;
    end
    if (!is_last) begin
      return;
    end
    ordered = held_bytes;
    ordered.rsort();
    n    = ordered.size();
    half = n / 2;
    // odd count: middle element, even count: truncated mean of the middle pair
    if (n % 2 == 1) begin
      median = ordered[half];
    end else begin
      median = (int'(ordered[half - 1]) + int'(ordered[half])) / 2;
    end
    beat.largest    = ordered[0];
    beat.smallest   = ordered[n - 1];
    beat.average    = byte_t'(held_sum / n);
    beat.middle     = byte_t'(median);
    beat.overflowed = held_over;
    for (int i = 0; i < n; i++) begin
      beat.sorted_byte = ordered[i];
      beat.final_res   = (i == n - 1);
      awaited_results.push_back(beat);
    end
    // set done, predictor is empty again
    held_bytes.delete();
    held_sum  = 0;
    held_over = 1'b0;
  endtask

  task automatic check_result();
    result_beat_t want;
    if (awaited_results.size() == 0) begin
      report($sformatf("result beat %0d with nothing expected", results_if.sorted_byte));
      return;
    end
    want = awaited_results.pop_front();
    check_field("sorted_byte", results_if.sorted_byte, want.sorted_byte);
    check_field("largest", results_if.largest, want.largest);
    check_field("smallest", results_if.smallest, want.smallest);
    check_field("average", results_if.average, want.average);
    check_field("middle", results_if.middle, want.middle);
    check_field("overflowed", results_if.overflowed, want.overflowed);
    check_field("final_res", results_if.final_res, want.final_res);
  endtask

  task automatic queue_byte(input byte_t sample, input logic is_last);
    sample_beat_t beat;
    beat.sample  = sample;
    beat.is_last = is_last;
    pending_samples.push_back(beat);
  endtask

  // a set of n bytes, the last one closing it; narrow value ranges force repeats
  task automatic queue_random_set(input int n, inout int queued);
    bit narrow;
    int base;
    narrow = ($urandom_range(0, 3) == 0);
    base   = $urandom_range(0, 250);
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        queue_byte(byte_t'(base + $urandom_range(0, 5)), i == n - 1);
      end else begin
        queue_byte(byte_t'($urandom_range(0, BYTE_MAX)), i == n - 1);
      end
    end
    queued += n;
  endtask

  // ---------------------------------------------------------------------------
  // sample driver: new beats go out on the falling edge, held until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_samples
    sample_beat_t beat;
    if (!rst) begin
      // only move on once the beat on the bus has been taken
      if (!samples_if.valid || sample_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          samples_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          beat = pending_samples.pop_front();
          samples_if.sample  <= beat.sample;
          samples_if.is_last <= beat.is_last;
          samples_if.valid   <= 1'b1;
          gap_left = pick_wait(in_run, in_quiet);
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: low for a random stall after each taken beat, then high
  always @(negedge clk) begin : drive_ready
    if (!rst) begin
      if (result_taken) begin
        stall_left = pick_wait(out_run, out_quiet);
      end
      if (stall_left > 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled on the rising edge; sample side first so
  // that expectations exist before any result of the same set is compared
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    sample_taken <= samples_if.valid && samples_if.ready;
    result_taken <= results_if.valid && results_if.ready;
    if (!rst) begin
      if (samples_if.valid && samples_if.ready) begin
        sort_and_summarise(samples_if.sample, samples_if.is_last);
      end
      if (results_if.valid && results_if.ready) begin
        check_result();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int queued;
    int n;
    samples_if.valid   = 1'b0;
    samples_if.sample  = '0;
    samples_if.is_last = 1'b0;
    results_if.ready   = 1'b0;
    sample_taken = 1'b0;
    result_taken = 1'b0;
    held_sum     = 0;
    held_over    = 1'b0;
    mismatches   = 0;
    gap_left     = 0;
    stall_left   = 0;
    in_run       = 0;
    out_run      = 0;
    in_quiet     = 1'b0;
    out_quiet    = 1'b0;
    queued       = 0;
    rst = 1'b1;

    // single-byte sets at both extremes
    queue_byte(8'd0, 1'b1);
    queue_byte(8'd255, 1'b1);
    // even counts: extremes, and a middle pair whose mean truncates
    queue_byte(8'd0, 1'b0);    queue_byte(8'd255, 1'b1);
    queue_byte(8'd1, 1'b0);    queue_byte(8'd2, 1'b1);
    // odd count arriving out of order
    queue_byte(8'd200, 1'b0);  queue_byte(8'd3, 1'b0);    queue_byte(8'd7, 1'b1);
    // all equal
    queue_byte(8'd5, 1'b0);    queue_byte(8'd5, 1'b0);    queue_byte(8'd5, 1'b1);
    // one bit per byte, ascending so every one has to move
    for (int b = 0; b < BYTE_W; b++) begin
      queue_byte(byte_t'(1 << b), b == BYTE_W - 1);
    end

    // a set that just fills the store, then one that overflows it, closing
    // byte dropped; after that mostly short sets and now and then a long one
    queue_random_set(MAX_ELEMENTS, queued);
    queue_random_set(MAX_ELEMENTS + $urandom_range(1, 5), queued);
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(40, MAX_ELEMENTS + 6);
      end else begin
        n = $urandom_range(1, 12);
      end
      queue_random_set(n, queued);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every sample accepted, then every expected result seen
    while (pending_samples.size() != 0 || samples_if.valid) begin
      @(posedge clk);
    end
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    // give any stray beat time to show up
    repeat (SETTLE_WAIT) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
